// ----- sv/llwb_pkg.sv -----
// llwb_pkg: shared types, codes and constants for the link liveness watchdog
// used by llwb_history and link_liveness_watchdog_backoff_top; no dependencies
package llwb_pkg;

    // sizing of the interval history and the backoff schedule
    localparam int HISTORY_DEPTH = 5;
    localparam int BACKOFF_STEPS = 7;

    localparam int HCNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int BSTEP_W = (BACKOFF_STEPS > 1) ? $clog2(BACKOFF_STEPS) : 1;
    localparam logic [BSTEP_W-1:0] BSTEP_LAST = BSTEP_W'(BACKOFF_STEPS - 1);

    // backoff delays in milliseconds
    localparam int TABLE_LEN = 7;
    localparam logic [15:0] BACKOFF_TABLE [TABLE_LEN] = '{
        16'd0, 16'd1000, 16'd2000, 16'd5000, 16'd10000, 16'd15000, 16'd30000
    };
    localparam int TABLE_LAST = (BACKOFF_STEPS - 1 < TABLE_LEN - 1) ?
                                (BACKOFF_STEPS - 1) : (TABLE_LEN - 1);

    localparam logic [13:0] MIN_JITTER_RANGE = 14'd100;
    localparam logic [19:0] INTERVAL_MAX     = 20'hFFFFF;

    // register reset values
    localparam logic [3:0]  MISS_THRESHOLD_RST = 4'd3;
    localparam logic [17:0] MIN_TIMEOUT_RST    = 18'd15000;
    localparam logic [17:0] MAX_TIMEOUT_RST    = 18'd120000;

    // register indexes (word address bits)
    localparam logic [1:0] REG_MISS_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_TIMEOUT    = 2'd1;
    localparam logic [1:0] REG_MAX_TIMEOUT    = 2'd2;

    // event codes
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_HEARTBEAT = 2'd1;
    localparam logic [1:0] CMD_SET_STATE = 2'd2;
    localparam logic [1:0] CMD_RECONNECT = 2'd3;

    // session states
    localparam logic [1:0] SESS_DISCONNECTED   = 2'd0;
    localparam logic [1:0] SESS_CONNECTING     = 2'd1;
    localparam logic [1:0] SESS_AUTHENTICATING = 2'd2;
    localparam logic [1:0] SESS_CONNECTED      = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  session_state_in;
        logic        immediate;
        logic [15:0] jitter_draw;
    } item_t;

    typedef struct packed {
        logic        liveness_expired;
        logic        reconnect_due;
        logic [15:0] scheduled_delay_ms;
        logic        schedule_kept;
        logic [17:0] armed_timeout_ms;
    } result_t;

    // history control from the event logic
    typedef struct packed {
        logic        push;
        logic        clear;
        logic [19:0] interval;
    } hist_ctrl_t;

    typedef struct packed {
        logic [3:0]  miss_threshold;
        logic [17:0] min_timeout_ms;
        logic [17:0] max_timeout_ms;
    } cfg_t;

    // base backoff delay for a step, clamped to the last table entry
    function automatic logic [15:0] backoff_base(input logic [BSTEP_W-1:0] step);
        logic [15:0] d;
        d = BACKOFF_TABLE[TABLE_LAST];
        for (int i = 0; i < TABLE_LAST; i++)
        begin
            if (int'(step) == i)
            begin
                d = BACKOFF_TABLE[i];
            end
        end
        return d;
    endfunction

endpackage

// ----- sv/llwb_history.sv -----
// llwb_history: heartbeat interval history and armed timeout calculation
// depends on llwb_pkg
module llwb_history
    import llwb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hist_ctrl_t  ctrl,
    input  cfg_t        cfg,
    output logic [17:0] timeout_ms
);

    logic [19:0]       hist_reg   [HISTORY_DEPTH];
    logic [19:0]       hist_next  [HISTORY_DEPTH];
    logic [19:0]       shift_val  [HISTORY_DEPTH];
    logic [HCNT_W-1:0] cnt_reg;
    logic [HCNT_W-1:0] cnt_next;
    logic              full;
    logic [19:0]       longest;
    logic [23:0]       product;
    logic [23:0]       clamped;

    assign full = (cnt_reg == HCNT_W'(HISTORY_DEPTH));

    // value each entry takes when the history shifts down
    for (genvar g = 0; g < HISTORY_DEPTH; g++)
    begin : g_entry
        if (g == HISTORY_DEPTH - 1)
        begin : g_last
            assign shift_val[g] = ctrl.interval;
        end
        else
        begin : g_mid
            assign shift_val[g] = hist_reg[g + 1];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            hist_next[i] = hist_reg[i];
            if (ctrl.push)
            begin
                if (full)
                begin
                    hist_next[i] = shift_val[i];
                end
                else if (cnt_reg == HCNT_W'(i))
                begin
                    hist_next[i] = ctrl.interval;
                end
            end
        end
        if (ctrl.clear)
        begin
            cnt_next = '0;
        end
        else if (ctrl.push && !full)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // longest interval over the entries held after this update
    always_comb
    begin
        longest = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            if ((HCNT_W'(i) < cnt_next) && (hist_next[i] > longest))
            begin
                longest = hist_next[i];
            end
        end
    end

    assign product = longest * cfg.miss_threshold;

    always_comb
    begin
        clamped = product;
        if (clamped > {6'd0, cfg.max_timeout_ms})
        begin
            clamped = {6'd0, cfg.max_timeout_ms};
        end
        if (clamped < {6'd0, cfg.min_timeout_ms})
        begin
            clamped = {6'd0, cfg.min_timeout_ms};
        end
        if ((cnt_next == '0) || (longest == '0))
        begin
            timeout_ms = '0;
        end
        else
        begin
            timeout_ms = clamped[17:0];
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- sv/link_liveness_watchdog_backoff_top.sv -----
// link_liveness_watchdog_backoff_top: link supervisor with liveness watchdog and reconnect backoff
// an item transfer reaches its result through the input register, then the result register
// throughput: one item per cycle while result_stall is low; input register refills as results drain
// reset: rst_n clears session, timers, backoff step and history count; registers take 3/15000/120000
// history entries are not reset, only entries below the fill count are ever read
// depends on llwb_pkg and llwb_history
module link_liveness_watchdog_backoff_top
    import llwb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // event channel
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    cfg_t cfg_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.miss_threshold <= MISS_THRESHOLD_RST;
            cfg_reg.min_timeout_ms <= MIN_TIMEOUT_RST;
            cfg_reg.max_timeout_ms <= MAX_TIMEOUT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MISS_THRESHOLD: cfg_reg.miss_threshold <= pwdata[3:0];
                REG_MIN_TIMEOUT:    cfg_reg.min_timeout_ms <= pwdata[17:0];
                REG_MAX_TIMEOUT:    cfg_reg.max_timeout_ms <= pwdata[17:0];
                default:            ;  // unmapped word, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MISS_THRESHOLD: prdata = {28'd0, cfg_reg.miss_threshold};
            REG_MIN_TIMEOUT:    prdata = {14'd0, cfg_reg.min_timeout_ms};
            REG_MAX_TIMEOUT:    prdata = {14'd0, cfg_reg.max_timeout_ms};
            default:            prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // transfer handling: input register feeds the result register
    // ---------------------------------------------------------------
    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    s1_adv;
    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;

    // the held item moves on whenever the result register is free or draining
    assign s1_adv       = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall   = s1_valid_reg && !s1_adv;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s1_adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_item_reg <= item;
        end
        if (s1_adv)
        begin
            res_reg <= res_next;
        end
    end

    // ---------------------------------------------------------------
    // supervisor state
    // ---------------------------------------------------------------
    logic [1:0]         session_reg,   session_next;
    logic               clk_valid_reg, clk_valid_next;
    logic [31:0]        hb_clock_reg,  hb_clock_next;
    logic [31:0]        last_hb_reg,   last_hb_next;
    logic [17:0]        live_rem_reg,  live_rem_next;
    logic               live_act_reg,  live_act_next;
    logic [BSTEP_W-1:0] bstep_reg,     bstep_next;
    logic [15:0]        rc_rem_reg,    rc_rem_next;
    logic               rc_act_reg,    rc_act_next;

    hist_ctrl_t  hctrl;
    logic [17:0] timeout_ms;
    logic [31:0] interval_raw;
    logic [19:0] interval_sat;
    logic        hb_eval;
    logic [15:0] base_delay;
    logic [13:0] jit_range;
    logic [29:0] jit_product;
    logic [15:0] req_delay;

    llwb_history u_history (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (hctrl),
        .cfg        (cfg_reg),
        .timeout_ms (timeout_ms)
    );

    // wrapped heartbeat interval, saturated to the history width
    assign interval_raw = hb_clock_reg - last_hb_reg;
    assign interval_sat = (|interval_raw[31:20]) ? INTERVAL_MAX : interval_raw[19:0];

    // only a heartbeat on a connected session with a running clock measures
    assign hb_eval = (s1_item_reg.command == CMD_HEARTBEAT)
                     && (session_reg == SESS_CONNECTED) && clk_valid_reg;

    // backoff delay with jitter scaled from the draw, a quarter of the base but at least 100
    assign base_delay  = backoff_base(bstep_reg);
    assign jit_range   = (base_delay[15:2] < MIN_JITTER_RANGE) ? MIN_JITTER_RANGE
                                                               : base_delay[15:2];
    assign jit_product = s1_item_reg.jitter_draw * jit_range;

    always_comb
    begin
        if (s1_item_reg.immediate || (base_delay == '0))
        begin
            req_delay = s1_item_reg.immediate ? 16'd0 : base_delay;
        end
        else
        begin
            req_delay = base_delay + {2'd0, jit_product[29:16]};
        end
    end

    always_comb
    begin
        session_next   = session_reg;
        clk_valid_next = clk_valid_reg;
        hb_clock_next  = hb_clock_reg;
        last_hb_next   = last_hb_reg;
        live_rem_next  = live_rem_reg;
        live_act_next  = live_act_reg;
        bstep_next     = bstep_reg;
        rc_rem_next    = rc_rem_reg;
        rc_act_next    = rc_act_reg;
        hctrl.push     = 1'b0;
        hctrl.clear    = 1'b0;
        hctrl.interval = interval_sat;
        res_next       = '0;

        case (s1_item_reg.command)
            CMD_TICK:
            begin
                if (clk_valid_reg)
                begin
                    hb_clock_next = hb_clock_reg + 32'd1;
                end
                // reconnect timer first, against the session before this tick
                if (rc_act_reg)
                begin
                    if (rc_rem_reg <= 16'd1)
                    begin
                        rc_act_next            = 1'b0;
                        rc_rem_next            = '0;
                        res_next.reconnect_due = (session_reg == SESS_DISCONNECTED);
                    end
                    else
                    begin
                        rc_rem_next = rc_rem_reg - 16'd1;
                    end
                end
                if (live_act_reg)
                begin
                    if (live_rem_reg <= 18'd1)
                    begin
                        live_act_next             = 1'b0;
                        live_rem_next             = '0;
                        res_next.liveness_expired = 1'b1;
                        // link lost: drop the watchdog and reconnect at once
                        if (session_reg != SESS_DISCONNECTED)
                        begin
                            clk_valid_next = 1'b0;
                            hb_clock_next  = '0;
                            last_hb_next   = '0;
                            hctrl.clear    = 1'b1;
                            session_next   = SESS_DISCONNECTED;
                            bstep_next     = '0;
                            rc_act_next    = 1'b1;
                            rc_rem_next    = '0;
                        end
                    end
                    else
                    begin
                        live_rem_next = live_rem_reg - 18'd1;
                    end
                end
            end

            CMD_HEARTBEAT:
            begin
                if ((session_reg == SESS_CONNECTED) && !clk_valid_reg)
                begin
                    // first heartbeat starts the clock
                    clk_valid_next = 1'b1;
                    hb_clock_next  = '0;
                    last_hb_next   = '0;
                end
                else if (hb_eval)
                begin
                    hctrl.push   = (interval_raw != '0);
                    last_hb_next = hb_clock_reg;
                    res_next.armed_timeout_ms = timeout_ms;
                    if (timeout_ms != '0)
                    begin
                        live_act_next = 1'b1;
                        live_rem_next = timeout_ms;
                    end
                end
            end

            CMD_SET_STATE:
            begin
                session_next = s1_item_reg.session_state_in;
            end

            default:  // reconnect request
            begin
                res_next.scheduled_delay_ms = req_delay;
                if (s1_item_reg.immediate)
                begin
                    bstep_next = '0;
                end
                else if (bstep_reg < BSTEP_LAST)
                begin
                    bstep_next = bstep_reg + 1'b1;
                end
                // a running timer that fires no later is left alone
                if (rc_act_reg && !s1_item_reg.immediate && (rc_rem_reg <= req_delay))
                begin
                    res_next.schedule_kept = 1'b1;
                end
                else
                begin
                    session_next = SESS_DISCONNECTED;
                    rc_act_next  = 1'b1;
                    rc_rem_next  = req_delay;
                end
            end
        endcase

        // history moves only with the item
        if (!s1_adv)
        begin
            hctrl.push  = 1'b0;
            hctrl.clear = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg   <= SESS_DISCONNECTED;
            clk_valid_reg <= 1'b0;
            hb_clock_reg  <= '0;
            last_hb_reg   <= '0;
            live_rem_reg  <= '0;
            live_act_reg  <= 1'b0;
            bstep_reg     <= '0;
            rc_rem_reg    <= '0;
            rc_act_reg    <= 1'b0;
        end
        else if (s1_adv)
        begin
            session_reg   <= session_next;
            clk_valid_reg <= clk_valid_next;
            hb_clock_reg  <= hb_clock_next;
            last_hb_reg   <= last_hb_next;
            live_rem_reg  <= live_rem_next;
            live_act_reg  <= live_act_next;
            bstep_reg     <= bstep_next;
            rc_rem_reg    <= rc_rem_next;
            rc_act_reg    <= rc_act_next;
        end
    end

`ifndef SYNTHESIS
    // expiry on a live session leaves an immediate reconnect pending
    a_expiry_reconnects: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (s1_item_reg.command == CMD_TICK) && live_act_reg
        && (live_rem_reg <= 18'd1) && (session_reg != SESS_DISCONNECTED)
        |=> rc_act_reg && (rc_rem_reg == 16'd0) && (session_reg == SESS_DISCONNECTED))
        else $error("liveness expiry did not start an immediate reconnect");

    // a reported armed timeout always leaves the liveness timer running
    a_armed_active: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (res_next.armed_timeout_ms != 18'd0) |=> live_act_reg)
        else $error("armed timeout without active liveness timer");

    // the heartbeat clock stays at zero while it is not running
    a_clock_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !clk_valid_reg |-> (hb_clock_reg == 32'd0))
        else $error("heartbeat clock moved while not valid");

    // a full input register behind a stalled result must hold off new transfers
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && res_valid_reg && result_stall |-> item_stall)
        else $error("input accepted while the pipeline is blocked");
`endif

endmodule

// ----- verif/link_liveness_watchdog_backoff_top_tb.sv -----
// link_liveness_watchdog_backoff_top_tb: self-checking bench for the link supervisor
// a directed opening then random sessions, checked against pinned results or an in-bench predictor
// depends on llwb_pkg and link_liveness_watchdog_backoff_top
module link_liveness_watchdog_backoff_top_tb;
    import llwb_pkg::*;

    localparam int ITEM_W        = $bits(item_t);
    localparam int NUM_SETTINGS  = 8;
    localparam int ITEMS_PER_SET = 100;
    localparam int QUIET_LIMIT   = 5000;
    // long receiver hold-off, started once this many results have been taken
    localparam int HOLD_AFTER    = 400;
    localparam int HOLD_CYCLES   = 300;

    localparam result_t ALL_CLEAR = '0;
    localparam result_t DUE_ONLY  = '{1'b0, 1'b1, 16'd0, 1'b0, 18'd0};
    localparam result_t KEPT_ONLY = '{1'b0, 1'b0, 16'd0, 1'b1, 18'd0};

    typedef struct {
        item_t   ev;
        bit      pinned;
        result_t want;
    } directed_row_t;

    // register settings walked phase by phase; the first one is the reset state
    cfg_t settings [NUM_SETTINGS] = '{
        '{MISS_THRESHOLD_RST, MIN_TIMEOUT_RST, MAX_TIMEOUT_RST},
        '{4'd1,  18'd0,      18'd262143},  // no lower clamp, widest upper clamp
        '{4'd15, 18'd20,     18'd60},      // largest multiplier, tight window
        '{4'd4,  18'd0,      18'd0},       // both limits zero, nothing can arm
        '{4'd0,  18'd0,      18'd262143},  // zero multiplier, nothing can arm
        '{4'd2,  18'd262143, 18'd5},       // crossed limits, lower clamp wins
        '{4'd3,  18'd6,      18'd30},
        '{4'd1,  18'd1,      18'd1}        // expires on the first tick after arming
    };

    // opening sequence: fixed results only where they are obvious, the rest predicted
    directed_row_t opening_script [26] = '{
        '{'{CMD_TICK,      SESS_CONNECTED,      1'b1, 16'hFFFF}, 1'b1, ALL_CLEAR},
        '{'{CMD_HEARTBEAT, SESS_CONNECTED,      1'b1, 16'hFFFF}, 1'b1, ALL_CLEAR},
        '{'{CMD_RECONNECT, SESS_DISCONNECTED,   1'b0, 16'hFFFF}, 1'b1, ALL_CLEAR},
        '{'{CMD_TICK,      SESS_DISCONNECTED,   1'b0, 16'h0000}, 1'b1, DUE_ONLY},
        '{'{CMD_RECONNECT, SESS_CONNECTED,      1'b0, 16'hFFFF}, 1'b0, ALL_CLEAR},
        '{'{CMD_RECONNECT, SESS_DISCONNECTED,   1'b0, 16'h0000}, 1'b0, ALL_CLEAR},
        '{'{CMD_RECONNECT, SESS_CONNECTED,      1'b1, 16'hFFFF}, 1'b1, ALL_CLEAR},
        '{'{CMD_SET_STATE, SESS_CONNECTED,      1'b1, 16'hFFFF}, 1'b1, ALL_CLEAR},
        '{'{CMD_TICK,      SESS_DISCONNECTED,   1'b0, 16'h0000}, 1'b1, ALL_CLEAR},
        '{'{CMD_HEARTBEAT, SESS_DISCONNECTED,   1'b0, 16'h0000}, 1'b1, ALL_CLEAR},
        '{'{CMD_HEARTBEAT, SESS_CONNECTED,      1'b1, 16'hFFFF}, 1'b1, ALL_CLEAR},
        '{'{CMD_TICK,      SESS_CONNECTING,     1'b0, 16'h5A5A}, 1'b1, ALL_CLEAR},
        '{'{CMD_HEARTBEAT, SESS_DISCONNECTED,   1'b0, 16'hA5A5}, 1'b0, ALL_CLEAR},
        '{'{CMD_SET_STATE, SESS_CONNECTING,     1'b0, 16'h0000}, 1'b1, ALL_CLEAR},
        '{'{CMD_HEARTBEAT, SESS_CONNECTED,      1'b1, 16'hFFFF}, 1'b1, ALL_CLEAR},
        '{'{CMD_SET_STATE, SESS_AUTHENTICATING, 1'b1, 16'hFFFF}, 1'b1, ALL_CLEAR},
        '{'{CMD_SET_STATE, SESS_DISCONNECTED,   1'b0, 16'h0000}, 1'b1, ALL_CLEAR},
        '{'{CMD_RECONNECT, SESS_AUTHENTICATING, 1'b1, 16'h0000}, 1'b1, ALL_CLEAR},
        '{'{CMD_RECONNECT, SESS_DISCONNECTED,   1'b0, 16'h0000}, 1'b1, KEPT_ONLY},
        '{'{CMD_RECONNECT, SESS_DISCONNECTED,   1'b0, 16'hFFFF}, 1'b0, ALL_CLEAR},
        '{'{CMD_RECONNECT, SESS_DISCONNECTED,   1'b0, 16'h8000}, 1'b0, ALL_CLEAR},
        '{'{CMD_RECONNECT, SESS_DISCONNECTED,   1'b0, 16'hFFFF}, 1'b0, ALL_CLEAR},
        '{'{CMD_RECONNECT, SESS_DISCONNECTED,   1'b0, 16'h0000}, 1'b0, ALL_CLEAR},
        '{'{CMD_RECONNECT, SESS_DISCONNECTED,   1'b0, 16'hFFFF}, 1'b0, ALL_CLEAR},
        '{'{CMD_RECONNECT, SESS_DISCONNECTED,   1'b0, 16'hFFFF}, 1'b0, ALL_CLEAR},
        '{'{CMD_RECONNECT, SESS_DISCONNECTED,   1'b0, 16'hFFFF}, 1'b0, ALL_CLEAR}
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the supervisor state and its registers
    cfg_t        cfg;
    logic [1:0]  sess;
    logic        hb_running;
    logic [31:0] hb_now;
    logic [31:0] hb_prev;
    logic [19:0] gaps [HISTORY_DEPTH];
    int          gap_fill;
    logic [17:0] live_left;
    logic        live_on;
    int          bo_idx;
    logic [15:0] rc_left;
    logic        rc_on;

    result_t     pending_outcomes [$];
    int unsigned mismatch_count = 0;
    int unsigned outcomes_seen  = 0;
    int unsigned events_sent    = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    int unsigned expiries_seen  = 0;
    int unsigned dues_seen      = 0;
    int unsigned kept_seen      = 0;
    int unsigned armed_seen     = 0;

    link_liveness_watchdog_backoff_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
    endfunction

    // expected outcome of one event; advances the predictor state
    function automatic result_t link_outcome(input item_t ev);
        result_t     r;
        logic [31:0] gap;
        logic [19:0] longest;
        logic [63:0] span;
        int unsigned base;
        int unsigned jrange;
        int unsigned delay;
        r     = '0;
        delay = 0;
        case (ev.command)
            CMD_TICK:
            begin
                if (hb_running)
                    hb_now = hb_now + 1;
                // reconnect timer first, judged on the session state before this tick
                if (rc_on)
                begin
                    if (rc_left <= 1)
                    begin
                        rc_on   = 1'b0;
                        rc_left = '0;
                        if (sess == SESS_DISCONNECTED)
                            r.reconnect_due = 1'b1;
                    end
                    else
                        rc_left = rc_left - 1;
                end
                if (live_on)
                begin
                    if (live_left <= 1)
                    begin
                        live_on            = 1'b0;
                        live_left          = '0;
                        r.liveness_expired = 1'b1;
                        // an active session drops and reconnects at once
                        if (sess != SESS_DISCONNECTED)
                        begin
                            hb_running = 1'b0;
                            hb_now     = '0;
                            hb_prev    = '0;
                            gap_fill   = 0;
                            sess       = SESS_DISCONNECTED;
                            bo_idx     = 0;
                            rc_on      = 1'b1;
                            rc_left    = '0;
                        end
                    end
                    else
                        live_left = live_left - 1;
                end
            end
            CMD_HEARTBEAT:
            begin
                if (sess == SESS_CONNECTED && !hb_running)
                begin
                    hb_running = 1'b1;
                    hb_now     = '0;
                    hb_prev    = '0;
                end
                else if (sess == SESS_CONNECTED)
                begin
                    gap = hb_now - hb_prev;
                    if (gap != 0)
                    begin
                        if (gap > INTERVAL_MAX)
                            gap = INTERVAL_MAX;
                        if (gap_fill >= HISTORY_DEPTH)
                        begin
                            for (int i = 0; i + 1 < HISTORY_DEPTH; i++)
                                gaps[i] = gaps[i + 1];
                            gaps[HISTORY_DEPTH - 1] = gap[19:0];
                        end
                        else
                        begin
                            gaps[gap_fill] = gap[19:0];
                            gap_fill++;
                        end
                    end
                    hb_prev = hb_now;
                    longest = '0;
                    for (int i = 0; i < gap_fill; i++)
                        if (gaps[i] > longest)
                            longest = gaps[i];
                    if (longest != 0)
                    begin
                        span = longest * cfg.miss_threshold;
                        if (span > cfg.max_timeout_ms)
                            span = cfg.max_timeout_ms;
                        if (span < cfg.min_timeout_ms)
                            span = cfg.min_timeout_ms;
                        r.armed_timeout_ms = span[17:0];
                    end
                    // a zero timeout leaves any running timer alone
                    if (r.armed_timeout_ms != 0)
                    begin
                        live_on   = 1'b1;
                        live_left = r.armed_timeout_ms;
                    end
                end
            end
            CMD_SET_STATE:
                sess = ev.session_state_in;
            CMD_RECONNECT:
            begin
                if (!ev.immediate)
                begin
                    base   = BACKOFF_TABLE[(bo_idx > TABLE_LAST) ? TABLE_LAST : bo_idx];
                    jrange = base / 4;
                    if (jrange < MIN_JITTER_RANGE)
                        jrange = MIN_JITTER_RANGE;
                    delay = base;
                    if (base > 0)
                        delay = base + ((64'(ev.jitter_draw) * jrange) >> 16);
                    if (bo_idx < BACKOFF_STEPS - 1)
                        bo_idx++;
                end
                else
                    bo_idx = 0;
                r.scheduled_delay_ms = delay[15:0];
                if (rc_on && !ev.immediate && rc_left <= delay)
                    r.schedule_kept = 1'b1;
                else
                begin
                    sess    = SESS_DISCONNECTED;
                    rc_on   = 1'b1;
                    rc_left = delay[15:0];
                end
            end
        endcase
        return r;
    endfunction

    // offer one event, hold it until the transfer, then record its expected outcome
    task automatic send_event(input item_t ev, input bit pinned = 1'b0,
                              input result_t pinned_want = '0);
        result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= ev;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        want    = link_outcome(ev);
        pending_outcomes.push_back(pinned ? pinned_want : want);
        expiries_seen += want.liveness_expired;
        dues_seen     += want.reconnect_due;
        kept_seen     += want.schedule_kept;
        armed_seen    += (want.armed_timeout_ms != 0);
        events_sent++;
    endtask

    // event of the given kind with random content in the other fields, the given state for a state change
    task automatic send_random_as(input logic [1:0] cmd, input logic [1:0] st);
        item_t ev;
        ev         = ITEM_W'($urandom);
        ev.command = cmd;
        if (cmd == CMD_SET_STATE)
            ev.session_state_in = st;
        send_event(ev);
    endtask

    task automatic run_sessions(input int unsigned target);
        int unsigned stop_at;
        int unsigned pick;
        item_t       ev;
        stop_at = events_sent + target;
        while (events_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // connect, a run of heartbeats, then a silence of ticks that may let it expire
                send_random_as(CMD_SET_STATE, SESS_CONNECTED);
                repeat ($urandom_range(8, 1))
                begin
                    repeat ($urandom_range(6, 0))
                        send_random_as(CMD_TICK, SESS_DISCONNECTED);
                    send_random_as(CMD_HEARTBEAT, SESS_DISCONNECTED);
                end
                if ($urandom_range(3) == 0)
                    send_random_as(CMD_SET_STATE, 2'($urandom));
                repeat ($urandom_range(70, 0))
                    send_random_as(CMD_TICK, SESS_DISCONNECTED);
            end
            else if (pick < 75)
            begin
                ev           = ITEM_W'($urandom);
                ev.command   = CMD_RECONNECT;
                ev.immediate = ($urandom_range(99) < 30);
                send_event(ev);
                repeat ($urandom_range(4, 0))
                    send_random_as(CMD_TICK, SESS_DISCONNECTED);
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(20, 1))
                    send_random_as(CMD_TICK, SESS_DISCONNECTED);
            end
            else
                send_event(ITEM_W'($urandom));
        end
    endtask

    task automatic reg_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering and let every outstanding transfer come back
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // receiver: check each result transfer, then choose the stall for the next cycle
    always @(posedge clk)
    begin
        result_t want;
        if (result_valid && !result_stall)
        begin
            outcomes_seen++;
            if (pending_outcomes.size() == 0)
                flag_mismatch("result with nothing outstanding", '0, result);
            else
            begin
                want = pending_outcomes.pop_front();
                if (result.liveness_expired != want.liveness_expired)
                    flag_mismatch($sformatf("result %0d liveness_expired", outcomes_seen),
                                  want.liveness_expired, result.liveness_expired);
                if (result.reconnect_due != want.reconnect_due)
                    flag_mismatch($sformatf("result %0d reconnect_due", outcomes_seen),
                                  want.reconnect_due, result.reconnect_due);
                if (result.scheduled_delay_ms != want.scheduled_delay_ms)
                    flag_mismatch($sformatf("result %0d scheduled_delay_ms", outcomes_seen),
                                  want.scheduled_delay_ms, result.scheduled_delay_ms);
                if (result.schedule_kept != want.schedule_kept)
                    flag_mismatch($sformatf("result %0d schedule_kept", outcomes_seen),
                                  want.schedule_kept, result.schedule_kept);
                if (result.armed_timeout_ms != want.armed_timeout_ms)
                    flag_mismatch($sformatf("result %0d armed_timeout_ms", outcomes_seen),
                                  want.armed_timeout_ms, result.armed_timeout_ms);
            end
        end
        // one long hold-off so the block fills up and pushes back on its input
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (!hold_done && outcomes_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // cycles with no transfer on either channel and no register access
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_outcomes.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [1:0]  reg_ids [3];
        logic [31:0] reg_vals [3];
        logic [31:0] rdata;
        reg_ids    = '{REG_MISS_THRESHOLD, REG_MIN_TIMEOUT, REG_MAX_TIMEOUT};
        cfg        = settings[0];
        sess       = SESS_DISCONNECTED;
        hb_running = 1'b0;
        hb_now     = '0;
        hb_prev    = '0;
        gaps       = '{default: '0};
        gap_fill   = 0;
        live_left  = '0;
        live_on    = 1'b0;
        bo_idx     = 0;
        rc_left    = '0;
        rc_on      = 1'b0;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            // receiver-heavy idling, then sender-heavy, then none at all
            if (p < 3)
            begin
                send_idle_pct = 38;
                recv_idle_pct = 57;
            end
            else if (p < 6)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 38;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            reg_vals = '{32'(settings[p].miss_threshold), 32'(settings[p].min_timeout_ms),
                         32'(settings[p].max_timeout_ms)};
            // the first pass only reads back the reset values
            for (int r = 0; r < 3; r++)
            begin
                if (p > 0)
                    reg_access(1'b1, reg_ids[r], reg_vals[r], rdata);
                reg_access(1'b0, reg_ids[r], '0, rdata);
                if (rdata != reg_vals[r])
                    flag_mismatch($sformatf("register %0d read back", r), reg_vals[r], rdata);
            end
            cfg = settings[p];
            if (p == 0)
            begin
                foreach (opening_script[i])
                    send_event(opening_script[i].ev, opening_script[i].pinned,
                               opening_script[i].want);
            end
            run_sessions(ITEMS_PER_SET);
        end
        settle();

        $display("ran %0d events across %0d register settings,", events_sent, NUM_SETTINGS);
        $display("three idle patterns and a long result hold");
        $display("seen: %0d liveness expiries, %0d reconnects due, %0d kept schedules,",
                 expiries_seen, dues_seen, kept_seen);
        $display("and %0d timeouts armed", armed_seen);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- link_liveness_watchdog_backoff_top.f -----
sv/llwb_pkg.sv
sv/llwb_history.sv
sv/link_liveness_watchdog_backoff_top.sv
verif/link_liveness_watchdog_backoff_top_tb.sv
